FILE: src/rtks_pkg.sv
`default_nettype none
package rtks_pkg;

   localparam int MAX_RECORDS = 64;
   localparam int MARK_COUNT  = 5;
   localparam int ADDR_W      = $clog2(MAX_RECORDS);
   localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

   // Mean by five as a multiply by round-up(2^14 / 5) and a shift. The error
   // stays below one part in a thousand over the sum range, so the floor is exact.
   localparam int MEAN_RECIP = 3277;
   localparam int MEAN_SHIFT = 14;
   localparam int SUM_W      = 11;
   localparam int PROD_W     = 23;

   typedef struct packed {
      logic [15:0] record_key;
      logic [7:0]  mark_zero;
      logic [7:0]  mark_one;
      logic [7:0]  mark_two;
      logic [7:0]  mark_three;
      logic [7:0]  mark_four;
      logic [63:0] tag_low;
      logic [15:0] tag_high;
      logic        last_record;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] out_key;
      logic [7:0]  out_mark_zero;
      logic [7:0]  out_mark_one;
      logic [7:0]  out_mark_two;
      logic [7:0]  out_mark_three;
      logic [7:0]  out_mark_four;
      logic [10:0] mark_sum;
      logic [7:0]  mark_mean;
      logic [63:0] out_tag_low;
      logic [15:0] out_tag_high;
      logic        final_out;
      logic        overflowed;
   } rsp_payload_type;

   typedef struct packed {
      logic [15:0] key;
      logic [7:0]  mark_zero;
      logic [7:0]  mark_one;
      logic [7:0]  mark_two;
      logic [7:0]  mark_three;
      logic [7:0]  mark_four;
      logic [63:0] tag_low;
      logic [15:0] tag_high;
   } record_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RD_I,
      ST_CAP_I,
      ST_CMP_J,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic rd_i;
      logic cap_i;
      logic cmp_j;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic i_more;
      logic j_more;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

FILE: src/rtks_ctrl.sv
`default_nettype none
module rtks_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_last,
   input  wire rtks_pkg::stat_type stat,
   output rtks_pkg::cmd_type      cmd,
   output logic                   req_stall
);

   rtks_pkg::state_type state_ff;
   rtks_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtks_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rtks_pkg::ST_LOAD: begin
            if (req_valid && req_last) state_in = rtks_pkg::ST_RD_I;
         end
         rtks_pkg::ST_RD_I: begin
            state_in = rtks_pkg::ST_CAP_I;
         end
         rtks_pkg::ST_CAP_I: begin
            state_in = stat.i_more ? rtks_pkg::ST_CMP_J : rtks_pkg::ST_EMIT;
         end
         rtks_pkg::ST_CMP_J: begin
            state_in = stat.j_more ? rtks_pkg::ST_CMP_J : rtks_pkg::ST_EMIT;
         end
         rtks_pkg::ST_EMIT: begin
            if (stat.out_free) begin
               state_in = stat.i_more ? rtks_pkg::ST_RD_I : rtks_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = rtks_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         rtks_pkg::ST_LOAD: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         rtks_pkg::ST_RD_I: begin
            cmd.rd_i = 1'b1;
         end
         rtks_pkg::ST_CAP_I: begin
            cmd.cap_i = 1'b1;
         end
         rtks_pkg::ST_CMP_J: begin
            cmd.cmp_j = 1'b1;
         end
         rtks_pkg::ST_EMIT: begin
            cmd.emit = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

FILE: src/rtks_dpath.sv
`default_nettype none
module rtks_dpath (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire rtks_pkg::cmd_type        cmd,
   input  wire rtks_pkg::req_payload_type req_payload,
   input  wire logic                     rsp_stall,
   output rtks_pkg::stat_type            stat,
   output logic                          rsp_valid,
   output rtks_pkg::rsp_payload_type     rsp_payload
);

   localparam logic [rtks_pkg::CNT_W-1:0] MAX_CNT = rtks_pkg::CNT_W'(rtks_pkg::MAX_RECORDS);

   rtks_pkg::record_type mem [rtks_pkg::MAX_RECORDS];
   rtks_pkg::record_type rdata_ff;
   rtks_pkg::record_type cur_ff, cur_in;
   rtks_pkg::record_type new_rec;
   rtks_pkg::record_type wdata;
   rtks_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [rtks_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [rtks_pkg::CNT_W-1:0]  i_ff, i_in;
   logic [rtks_pkg::CNT_W-1:0]  j_ff, j_in;
   logic [rtks_pkg::CNT_W-1:0]  i_next, j_next;
   logic                        drop_ff, drop_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        wr_en;
   logic                        swap;
   logic [rtks_pkg::ADDR_W-1:0] waddr, raddr;
   logic [rtks_pkg::SUM_W-1:0]  sum;
   logic [rtks_pkg::PROD_W-1:0] prod;

   assign i_next = i_ff + 1'b1;
   assign j_next = j_ff + 1'b1;

   assign stat.i_more   = i_next < count_ff;
   assign stat.j_more   = j_next < count_ff;
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign swap = cmd.cmp_j && (cur_ff.key < rdata_ff.key);

   always_comb begin
      new_rec.key        = req_payload.record_key;
      new_rec.mark_zero  = req_payload.mark_zero;
      new_rec.mark_one   = req_payload.mark_one;
      new_rec.mark_two   = req_payload.mark_two;
      new_rec.mark_three = req_payload.mark_three;
      new_rec.mark_four  = req_payload.mark_four;
      new_rec.tag_low    = req_payload.tag_low;
      new_rec.tag_high   = req_payload.tag_high;
   end

   // One write port: new records while loading, displaced records while sorting.
   always_comb begin
      wr_en = 1'b0;
      waddr = count_ff[rtks_pkg::ADDR_W-1:0];
      wdata = new_rec;
      if (cmd.load && (count_ff < MAX_CNT)) begin
         wr_en = 1'b1;
      end else if (swap) begin
         wr_en = 1'b1;
         waddr = j_ff[rtks_pkg::ADDR_W-1:0];
         wdata = cur_ff;
      end
   end

   always_comb begin
      if (cmd.rd_i) begin
         raddr = i_ff[rtks_pkg::ADDR_W-1:0];
      end else if (cmd.cap_i) begin
         raddr = i_next[rtks_pkg::ADDR_W-1:0];
      end else begin
         raddr = j_next[rtks_pkg::ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cur_in   = cur_ff;
      if (cmd.load) begin
         if (count_ff < MAX_CNT) begin
            count_in = count_ff + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
      if (cmd.cap_i) begin
         cur_in = rdata_ff;
         j_in   = i_next;
      end
      if (cmd.cmp_j) begin
         j_in = j_next;
         if (swap) cur_in = rdata_ff;
      end
      if (cmd.emit) begin
         if (stat.i_more) begin
            i_in = i_next;
         end else begin
            i_in     = '0;
            count_in = '0;
            drop_in  = 1'b0;
         end
      end
   end

   always_comb begin
      sum = rtks_pkg::SUM_W'(cur_ff.mark_zero) + rtks_pkg::SUM_W'(cur_ff.mark_one)
          + rtks_pkg::SUM_W'(cur_ff.mark_two) + rtks_pkg::SUM_W'(cur_ff.mark_three)
          + rtks_pkg::SUM_W'(cur_ff.mark_four);
      prod = rtks_pkg::PROD_W'(sum) * rtks_pkg::PROD_W'(rtks_pkg::MEAN_RECIP);
   end

   always_comb begin
      rsp_in.out_key        = cur_ff.key;
      rsp_in.out_mark_zero  = cur_ff.mark_zero;
      rsp_in.out_mark_one   = cur_ff.mark_one;
      rsp_in.out_mark_two   = cur_ff.mark_two;
      rsp_in.out_mark_three = cur_ff.mark_three;
      rsp_in.out_mark_four  = cur_ff.mark_four;
      rsp_in.mark_sum       = sum;
      rsp_in.mark_mean      = prod[rtks_pkg::MEAN_SHIFT+7:rtks_pkg::MEAN_SHIFT];
      rsp_in.out_tag_low    = cur_ff.tag_low;
      rsp_in.out_tag_high   = cur_ff.tag_high;
      rsp_in.final_out      = !stat.i_more;
      rsp_in.overflowed     = drop_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drop_ff      <= drop_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A record is emitted only when the output register is empty or draining.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while a result waits");

   // The held record takes the larger key after a compare step.
   a_swap_keeps_max: assert property (@(posedge clock) disable iff (reset)
      swap |=> (cur_ff.key == $past(rdata_ff.key)))
      else $error("held record did not take the larger key");

   // The compare index always points at a stored entry.
   a_j_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp_j |-> (j_ff < count_ff))
      else $error("compare index beyond stored records");

   // The drop flag rises only when a record arrives at a full store.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      $rose(drop_ff) |-> ($past(count_ff) == MAX_CNT))
      else $error("drop flag set while the store had room");

endmodule
`default_nettype wire

FILE: src/record_total_and_key_sort_unit.sv
// Record total and key sort unit.
// Unless stalled, records arrive one item per cycle on req_ (req_valid, req_stall,
// req_payload) and are stored in arrival order, up to 64 of them. Records that
// arrive when the store is full are dropped, and every result of that set has
// overflowed set. An item with last_record set (stored or dropped) closes the set.
// The block then sorts the set by key in descending order with an exchange sort:
// for each position it holds one record in a register and walks the later
// entries through the single read port of the record memory, trading places
// whenever a later key is larger. Each position is final after its pass and is
// emitted at once on the rsp_ channel with the mark sum, the sum divided by five,
// and final_out on the last record of the set.
// Each pass reads position i, captures it in the held register, compares it with
// each later entry in turn and then emits it, waiting while a stalled result
// holds the output register. req_stall stays high from the last item until the
// final result has been loaded into the output register.
// A stall on rsp_ holds the output register and pauses the sort at the next
// result; the sort resumes when the waiting result is taken.
// Reset clears the record count, the drop flag, the state machine and the output
// valid. The record memory is not cleared: only entries of the current set are read.
`default_nettype none
module record_total_and_key_sort_unit (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire rtks_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rtks_pkg::rsp_payload_type      rsp_payload
);

   // Commands from the sequencer and status back from the datapath.
   rtks_pkg::cmd_type  cmd;
   rtks_pkg::stat_type stat;

   rtks_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_payload.last_record),
      .stat      (stat),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   rtks_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire
